>>> sv/b64d_pkg.sv
package b64d_pkg;

  localparam int QueueDepth = 2;

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChSlash  = 8'h2F;

  localparam logic [5:0] ValLowerBase = 6'd26;
  localparam logic [5:0] ValDigitBase = 6'd52;
  localparam logic [5:0] ValPlus      = 6'd62;
  localparam logic [5:0] ValSlash     = 6'd63;

  localparam logic [15:0] LimitReset = 16'hFFFF;

  localparam logic KindByte    = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      nbytes;
    logic            summary;
    logic [15:0]     total;
  } b64d_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64d_qstat_t;

  // {in alphabet, six-bit value}
  function automatic logic [6:0] sixbit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= ChUpperA && c <= ChUpperZ) begin
      d = c - ChUpperA;
      return {1'b1, d[5:0]};
    end else if (c >= ChLowerA && c <= ChLowerZ) begin
      d = c - ChLowerA;
      return {1'b1, d[5:0] + ValLowerBase};
    end else if (c >= ChDigit0 && c <= ChDigit9) begin
      d = c - ChDigit0;
      return {1'b1, d[5:0] + ValDigitBase};
    end else if (c == ChPlus) begin
      return {1'b1, ValPlus};
    end else if (c == ChSlash) begin
      return {1'b1, ValSlash};
    end
    return 7'd0;
  endfunction

endpackage

>>> sv/b64d_if.sv
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;
  modport source (output valid, text_char, end_of_text, input ready);
  modport sink (input valid, text_char, end_of_text, output ready);
endinterface

interface b64d_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        result_kind;
  logic [15:0] total_bytes;
  logic        run_last;
  modport source (output valid, data_byte, result_kind, total_bytes, run_last, input ready);
  modport sink (input valid, data_byte, result_kind, total_bytes, run_last, output ready);
endinterface

interface b64d_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] max_output_bytes;
  modport source (output valid, max_output_bytes, input ready);
  modport sink (input valid, max_output_bytes, output ready);
endinterface

>>> sv/b64d_front.sv
module b64d_front (
  input  logic                   clk,
  input  logic                   rst_n,
  b64d_in_if.sink                in_ch,
  b64d_cfg_if.sink               cfg_ch,
  input  b64d_pkg::b64d_qstat_t  qs,
  output logic                   push,
  output b64d_pkg::b64d_entry_t  entry
);

  logic [15:0] limit_r;
  logic [5:0]  gv_r [4];
  logic [5:0]  gv_nxt [4];
  logic [5:0]  gv_w [4];
  logic [1:0]  gcnt_r, gcnt_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic [15:0] emitted_r, emitted_nxt;

  logic            in_fire;
  logic [6:0]      sx;
  logic            rel;
  logic [15:0]     e1, e2, room;
  logic [2:0]      cnt1, nvals;
  logic            done;
  logic [1:0]      ngrp, n;
  logic [2:0][7:0] grp_bytes;
  logic            hold, emit;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !qs.full;
  assign in_fire      = in_ch.valid && !qs.full;

  always_comb begin
    sx   = b64d_pkg::sixbit(in_ch.text_char);
    rel  = held_valid_r && (emitted_r < limit_r);
    e1   = emitted_r + {15'd0, rel};
    gv_w = gv_r;
    cnt1 = {1'b0, gcnt_r};
    nvals = 3'd0;
    done  = 1'b0;
    if (sx[6]) begin
      gv_w[gcnt_r] = sx[5:0];
      cnt1 = {1'b0, gcnt_r} + 3'd1;
      if (cnt1 == 3'd4) begin
        nvals = 3'd4;
        done  = 1'b1;
      end
    end else begin
      nvals = {1'b0, gcnt_r};
      done  = 1'b1;
    end
    grp_bytes[0] = {gv_w[0], gv_w[1][5:4]};
    grp_bytes[1] = {gv_w[1][3:0], gv_w[2][5:2]};
    grp_bytes[2] = {gv_w[2][1:0], gv_w[3]};
    room = (e1 < limit_r) ? (limit_r - e1) : 16'd0;
    ngrp = (nvals > 3'd1) ? 2'(nvals - 3'd1) : 2'd0;
    n    = (room < {14'd0, ngrp}) ? room[1:0] : ngrp;
    hold = done && (nvals == 3'd2) && (n != 2'd0);
    emit = done && (nvals != 3'd2);
    e2   = e1 + (emit ? {14'd0, n} : 16'd0);

    // a released held byte never coincides with group bytes
    if (rel) begin
      entry.data   = {16'd0, held_byte_r};
      entry.nbytes = 2'd1;
    end else begin
      entry.data   = grp_bytes;
      entry.nbytes = emit ? n : 2'd0;
    end
    entry.summary = in_ch.end_of_text;
    entry.total   = in_ch.end_of_text ? e2 : 16'd0;
    push = in_fire && ((entry.nbytes != 2'd0) || in_ch.end_of_text);

    gv_nxt         = gv_r;
    gcnt_nxt       = gcnt_r;
    held_valid_nxt = held_valid_r;
    held_byte_nxt  = held_byte_r;
    emitted_nxt    = emitted_r;
    if (in_fire) begin
      if (in_ch.end_of_text) begin
        gv_nxt         = '{default: 6'd0};
        gcnt_nxt       = 2'd0;
        held_valid_nxt = 1'b0;
        held_byte_nxt  = 8'd0;
        emitted_nxt    = 16'd0;
      end else begin
        gv_nxt         = done ? '{default: 6'd0} : gv_w;
        gcnt_nxt       = done ? 2'd0 : cnt1[1:0];
        held_valid_nxt = hold;
        held_byte_nxt  = hold ? grp_bytes[0] : 8'd0;
        emitted_nxt    = e2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r      <= b64d_pkg::LimitReset;
      gv_r         <= '{default: 6'd0};
      gcnt_r       <= 2'd0;
      held_byte_r  <= 8'd0;
      held_valid_r <= 1'b0;
      emitted_r    <= 16'd0;
    end else begin
      if (cfg_ch.valid) begin
        limit_r <= cfg_ch.max_output_bytes;
      end
      gv_r         <= gv_nxt;
      gcnt_r       <= gcnt_nxt;
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      emitted_r    <= emitted_nxt;
    end
  end

endmodule

>>> sv/b64d_queue.sv
module b64d_queue #(
  parameter int Depth = b64d_pkg::QueueDepth
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  b64d_pkg::b64d_entry_t  push_entry,
  input  logic                   pop,
  output b64d_pkg::b64d_entry_t  head,
  output b64d_pkg::b64d_qstat_t  qs
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  b64d_pkg::b64d_entry_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign qs.full  = (cnt_r == FullCnt);
  assign qs.empty = (cnt_r == '0);
  assign head     = mem_r[rd_ptr_r];
  assign do_push  = push && !qs.full;
  assign do_pop   = pop && !qs.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> sv/b64d_back.sv
module b64d_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  b64d_pkg::b64d_entry_t  head,
  input  b64d_pkg::b64d_qstat_t  qs,
  output logic                   pop,
  b64d_out_if.source             out_ch
);

  b64d_pkg::b64d_entry_t cur_r, cur_nxt;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [2:0] nres;
  logic       is_last, is_byte, fire, finish;

  always_comb begin
    nres    = {1'b0, cur_r.nbytes} + {2'b0, cur_r.summary};
    is_last = ({1'b0, idx_r} == (nres - 3'd1));
    is_byte = (idx_r < cur_r.nbytes);

    out_ch.valid       = cur_valid_r;
    out_ch.data_byte   = is_byte ? cur_r.data[idx_r] : 8'd0;
    out_ch.result_kind = is_byte ? b64d_pkg::KindByte : b64d_pkg::KindSummary;
    out_ch.total_bytes = is_byte ? 16'd0 : cur_r.total;
    out_ch.run_last    = is_last;

    fire   = cur_valid_r && out_ch.ready;
    finish = fire && is_last;
    pop    = !qs.empty && (!cur_valid_r || finish);

    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    priority if (pop) begin
      cur_nxt       = head;
      cur_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end else if (finish) begin
      cur_valid_nxt = 1'b0;
      idx_nxt       = 2'd0;
    end else if (fire) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

>>> sv/base64_stream_decoder_unit.sv
// Streaming base64 decoder: one character per cycle goes in on in_ch while the
// queue is not full, decoded bytes and one end-of-string summary per string come
// out on out_ch, one result per cycle while out_ch is ready. A character causes
// up to four results; the front end decodes it in the cycle it is accepted and
// places its results as one entry in a QueueDepth-entry queue, and the output
// stage drains an entry one result at a time. Characters that cause no result
// cost the back end nothing, so with out_ch always ready the input sustains one
// character per cycle as long as no run of characters yields more than one
// result each on average (about three bytes per four characters in normal
// text). The byte limit on cfg_ch takes effect for the next character.
module base64_stream_decoder_unit #(
  parameter int QueueDepth = b64d_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  b64d_in_if.sink     in_ch,
  b64d_out_if.source  out_ch,
  b64d_cfg_if.sink    cfg_ch
);

  b64d_pkg::b64d_entry_t push_entry, head;
  b64d_pkg::b64d_qstat_t qs;
  logic push, pop;

  b64d_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .qs     (qs),
    .push   (push),
    .entry  (push_entry)
  );

  b64d_queue #(.Depth(QueueDepth)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qs         (qs)
  );

  b64d_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .qs     (qs),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

>>> sv/b64d_checker.sv
module b64d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_data_byte,
  input logic        out_result_kind,
  input logic [15:0] out_total_bytes,
  input logic        out_run_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte) &&
      $stable(out_result_kind) && $stable(out_total_bytes) && $stable(out_run_last))
    else $error("result changed while stalled");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind |-> out_run_last && (out_data_byte == 8'd0))
    else $error("summary not final or carries data");

  a_byte_no_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_result_kind |-> (out_total_bytes == 16'd0))
    else $error("byte result carries a total");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_data_byte   (out_ch.data_byte),
  .out_result_kind (out_ch.result_kind),
  .out_total_bytes (out_ch.total_bytes),
  .out_run_last    (out_ch.run_last)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [7:0] ChPad = 8'h3D;

  typedef struct packed {
    logic [7:0]  data;
    logic        kind;
    logic [15:0] total;
    logic        run_last;
  } dec_result_t;

  logic clk;
  logic rst_n;

  b64d_in_if  in_ch();
  b64d_out_if out_ch();
  b64d_cfg_if cfg_ch();

  base64_stream_decoder_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // decoder state mirror
  logic [5:0]  grp_vals [4];
  int          grp_cnt;
  logic [7:0]  held_byte;
  logic        held_valid;
  logic [15:0] emitted_bytes;
  logic [15:0] byte_limit;

  dec_result_t pending_results[$];
  dec_result_t want;
  int          fail_count;
  int          items_sent;
  bit          in_gaps_on;
  bit          out_stalls_on;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic int char_value(input logic [7:0] c);
    if (c >= b64d_pkg::ChUpperA && c <= b64d_pkg::ChUpperZ)
      return int'(c - b64d_pkg::ChUpperA);
    if (c >= b64d_pkg::ChLowerA && c <= b64d_pkg::ChLowerZ)
      return int'(c - b64d_pkg::ChLowerA) + 26;
    if (c >= b64d_pkg::ChDigit0 && c <= b64d_pkg::ChDigit9)
      return int'(c - b64d_pkg::ChDigit0) + 52;
    if (c == b64d_pkg::ChPlus) return 62;
    if (c == b64d_pkg::ChSlash) return 63;
    return -1;
  endfunction

  function automatic logic [7:0] pick_b64_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return b64d_pkg::ChUpperA + 8'(r);
    if (r < 52) return b64d_pkg::ChLowerA + 8'(r - 26);
    if (r < 62) return b64d_pkg::ChDigit0 + 8'(r - 52);
    if (r == 62) return b64d_pkg::ChPlus;
    return b64d_pkg::ChSlash;
  endfunction

  function automatic int room_left();
    if (emitted_bytes >= byte_limit) return 0;
    return int'(byte_limit) - int'(emitted_bytes);
  endfunction

  task automatic clear_string();
    for (int i = 0; i < 4; i++) grp_vals[i] = 6'd0;
    grp_cnt = 0;
    held_byte = 8'd0;
    held_valid = 1'b0;
    emitted_bytes = 16'd0;
  endtask

  task automatic predict_char(input logic [7:0] c, input logic eot);
    dec_result_t res [4];
    logic [7:0]  b [3];
    int          k;
    int          v;
    int          nvals;
    int          n;
    bit          done;
    k = 0;
    nvals = 0;
    done = 1'b0;
    if (held_valid) begin
      if (room_left() > 0) begin
        res[k++] = '{data: held_byte, kind: b64d_pkg::KindByte, total: 16'd0,
                     run_last: 1'b0};
        emitted_bytes++;
      end
      held_valid = 1'b0;
      held_byte = 8'd0;
    end
    v = char_value(c);
    if (v >= 0) begin
      grp_vals[grp_cnt % 4] = 6'(v);
      grp_cnt++;
      if (grp_cnt >= 4) begin
        nvals = 4;
        done = 1'b1;
      end
    end else begin
      nvals = grp_cnt;
      done = 1'b1;
    end
    if (done) begin
      b[0] = {grp_vals[0], grp_vals[1][5:4]};
      b[1] = {grp_vals[1][3:0], grp_vals[2][5:2]};
      b[2] = {grp_vals[2][1:0], grp_vals[3]};
      n = (nvals > 1) ? nvals - 1 : 0;
      if (n > room_left()) n = room_left();
      if (nvals == 2) begin
        // three characters only: byte waits for one more character
        if (n > 0) begin
          held_byte = b[0];
          held_valid = 1'b1;
        end
      end else begin
        for (int i = 0; i < n; i++) begin
          res[k++] = '{data: b[i], kind: b64d_pkg::KindByte, total: 16'd0,
                       run_last: 1'b0};
          emitted_bytes++;
        end
      end
      grp_cnt = 0;
      for (int i = 0; i < 4; i++) grp_vals[i] = 6'd0;
    end
    if (eot) begin
      res[k++] = '{data: 8'd0, kind: b64d_pkg::KindSummary, total: emitted_bytes,
                   run_last: 1'b0};
      clear_string();
    end
    for (int i = 0; i < k; i++) begin
      if (i == k - 1) res[i].run_last = 1'b1;
      pending_results.push_back(res[i]);
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic eot);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.text_char = c;
    in_ch.end_of_text = eot;
    do @(posedge clk); while (!in_ch.ready);
    predict_char(c, eot);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit eot);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eot && (i == s.len() - 1));
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_results.size() > 0) @(negedge clk);
    // characters with no result may still be in flight
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] lim);
    wait_drained();
    cfg_ch.valid = 1'b1;
    cfg_ch.max_output_bytes = lim;
    do @(posedge clk); while (!cfg_ch.ready);
    byte_limit = lim;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(1, 12));
      4:       return 16'($urandom_range(13, 60));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_random_string();
    logic [7:0] text[$];
    int         ngroups;
    int         len;
    if ($urandom_range(0, 9) < 7) begin
      ngroups = $urandom_range(0, 6);
      repeat (ngroups * 4) text.push_back(pick_b64_char());
      case ($urandom_range(0, 3))
        1: begin
          repeat (2) text.push_back(pick_b64_char());
          repeat (2) text.push_back(ChPad);
        end
        2: begin
          repeat (3) text.push_back(pick_b64_char());
          text.push_back(ChPad);
        end
        3: begin
          repeat (2) text.push_back(pick_b64_char());
          text.push_back(ChPad);
        end
        default: ;
      endcase
      if (text.size() == 0) text.push_back(pick_b64_char());
    end else begin
      len = $urandom_range(1, 16);
      repeat (len) begin
        case ($urandom_range(0, 3))
          0:       text.push_back(ChPad);
          1:       text.push_back(8'($urandom_range(0, 255)));
          default: text.push_back(pick_b64_char());
        endcase
      end
    end
    for (int i = 0; i < text.size(); i++) begin
      if (i > 0 && i % 4 == 0 && $urandom_range(0, 24) == 0) write_limit(pick_limit());
      send_char(text[i], i == text.size() - 1);
    end
  endtask

  task automatic test_directed();
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    send_text("QUJD/+9zQQ==", 1'b1);
    send_text("QQ=", 1'b1);
    send_text("Zz9", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_text("Aa09QU", 1'b1);
  endtask

  task automatic test_limits();
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    write_limit(16'd0);
    send_text("QUJD=", 1'b1);
    write_limit(16'd2);
    send_text("QUJD", 1'b0);
    write_limit(16'hFFFF);
    send_text("QUJD", 1'b1);
    write_limit(16'd4);
    send_text("QUJDQQ=", 1'b0);
    write_limit(16'd3);
    send_text("A", 1'b1);
    write_limit(16'hFFFF);
  endtask

  task automatic test_pause();
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    send_text("QUJDQQ=", 1'b0);
    wait_drained();
    send_text("QUJD", 1'b1);
  endtask

  task automatic test_random_strings();
    int goal;
    goal = items_sent + 240;
    while (items_sent < goal) begin
      if ($urandom_range(0, 3) == 0) write_limit(pick_limit());
      in_gaps_on = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      send_random_string();
    end
  endtask

  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = out_stalls_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_ch.data_byte !== want.data)
          report_mismatch($sformatf("data_byte %0h, want %0h", out_ch.data_byte, want.data));
        if (out_ch.result_kind !== want.kind)
          report_mismatch($sformatf("result_kind %0b, want %0b", out_ch.result_kind,
                                    want.kind));
        if (out_ch.total_bytes !== want.total)
          report_mismatch($sformatf("total_bytes %0d, want %0d", out_ch.total_bytes,
                                    want.total));
        if (out_ch.run_last !== want.run_last)
          report_mismatch($sformatf("run_last %0b, want %0b", out_ch.run_last,
                                    want.run_last));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : main_seq
    int spins;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.text_char = 8'd0;
    in_ch.end_of_text = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_output_bytes = 16'd0;
    fail_count = 0;
    items_sent = 0;
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    byte_limit = b64d_pkg::LimitReset;
    clear_string();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_limits();
    test_pause();
    test_random_strings();

    in_ch.valid = 1'b0;
    spins = 0;
    while (pending_results.size() > 0 && spins < 5000) begin
      @(negedge clk);
      spins++;
    end
    repeat (20) @(negedge clk);
    if (pending_results.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
